>>> hdl/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg - shared definitions for the moving-window mean/stddev core
// Field widths, parameter defaults, and the control/status types of the
// shared square-root/divide unit.
// ----------------------------------------------------------------------------
package swms_pkg;

  // Parameter defaults
  localparam int DEF_DEPTH       = 256;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int CFG_W  = 9;   // window_len register
  localparam int FILL_W = 9;   // fill_count
  localparam int MEAN_W = 24;  // mean_q8
  localparam int STD_W  = 24;  // stddev_q8

  // Window length after reset (before clamping to the ring depth)
  localparam int WIN_RESET = 256;

  // Fraction bits of the statistics
  localparam int FRAC_BITS = 8;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Operation of the shared iterative unit
  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } swms_op_e;

  typedef struct packed {
    logic     start;
    swms_op_e op;
  } swms_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swms_stat_t;

endpackage

>>> hdl/swms_sqdiv.sv
// ----------------------------------------------------------------------------
// swms_sqdiv - shared iterative square root / divider
// Restoring digit recurrence with one compare/subtract: square root takes
// two radicand bits per cycle, division one dividend bit per cycle.
// ----------------------------------------------------------------------------
module swms_sqdiv #(
  parameter int ROOT_W = 32,
  parameter int DIV_W  = 32,
  parameter int CNT_W  = 9
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  swms_pkg::swms_ctrl_t                        ctrl_i,
  input  logic [2*ROOT_W-1:0]                         op_a_i,     // radicand, or dividend in low bits
  input  logic [CNT_W-1:0]                            divisor_i,
  output swms_pkg::swms_stat_t                        stat_o,
  output logic [swms_pkg::max2(ROOT_W, DIV_W)-1:0]    result_o,
  output logic                                        rem_nz_o
);
  import swms_pkg::*;

  localparam int SRC_W  = 2 * ROOT_W;
  localparam int RES_W  = max2(ROOT_W, DIV_W);
  localparam int REM_W  = max2(ROOT_W + 3, CNT_W + 2);
  localparam int STEP_W = $clog2(RES_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  swms_op_e          op_q, op_d;
  logic [SRC_W-1:0]  src_q, src_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              fits;

  // One recurrence step: shift in the next digit, try to subtract
  always_comb begin
    unique case (op_q)
      OP_SQRT: begin
        shifted = {rem_q[REM_W-3:0], src_q[SRC_W-1 -: 2]};
        trial   = REM_W'({res_q[ROOT_W-1:0], 2'b01});
      end
      OP_DIV: begin
        shifted = {rem_q[REM_W-2:0], src_q[SRC_W-1]};
        trial   = REM_W'(dvs_q);
      end
      default: begin
        shifted = rem_q;
        trial   = REM_W'(dvs_q);
      end
    endcase
    diff = {1'b0, shifted} - {1'b0, trial};
    fits = ~diff[REM_W];
  end

  // Sequence the steps; a start always reloads the unit
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    src_d  = src_q;
    rem_d  = rem_q;
    res_d  = res_q;
    dvs_d  = dvs_q;
    if (busy_q && (cnt_q != '0)) begin
      cnt_d = cnt_q - STEP_W'(1);
      rem_d = fits ? diff[REM_W-1:0] : shifted;
      res_d = {res_q[RES_W-2:0], fits};
      src_d = (op_q == OP_SQRT) ? (src_q << 2) : (src_q << 1);
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctrl_i.op;
      rem_d  = '0;
      res_d  = '0;
      dvs_d  = divisor_i;
      if (ctrl_i.op == OP_SQRT) begin
        cnt_d = STEP_W'(ROOT_W);
        src_d = op_a_i;
      end else begin
        cnt_d = STEP_W'(DIV_W);
        src_d = SRC_W'(op_a_i[DIV_W-1:0]) << (SRC_W - DIV_W);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_SQRT;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    rem_q <= rem_d;
    res_q <= res_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);
  assign result_o    = res_q;
  assign rem_nz_o    = (rem_q != '0);

endmodule

>>> hdl/sliding_window_mean_stddev_core.sv
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev_core - moving-window mean and std deviation
// Keeps the last window_len samples in a ring with an exact running sum and
// sum of squares, and returns count, mean and population stddev in Q.8.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Beat contents (low bit first)
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | sample
//  m_axis   | out       | fill_count, mean_q8, stddev_q8, zero pad
//  cfg      | in        | window_len (write clears the window)
//
//  Per sample, the running sums and the variance numerator are first formed
//  on the shared multiplier; then one mean division, one square root and one
//  stddev division run one after another on the shared unit, one result bit
//  per cycle. s_axis_tready is high only while idle and no window length
//  write is present. A finished result waits in the output register until
//  taken; the next sample can be accepted meanwhile. Reset empties the window
//  and sets window_len to 256 (or DEPTH if smaller); ring contents are not
//  cleared, since an entry is only evicted after it has been written.
//
module sliding_window_mean_stddev_core #(
  parameter int DEPTH       = swms_pkg::DEF_DEPTH,
  parameter int SAMPLE_BITS = swms_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config
  input  logic                                 cfg_wr_en_i,
  input  logic [swms_pkg::CFG_W-1:0]           cfg_wr_data_i,  // window_len
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // sample
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((swms_pkg::FILL_W+swms_pkg::MEAN_W+swms_pkg::STD_W+7)/8)*8-1:0]
                                               m_axis_tdata    // fill_count, mean_q8,
                                                               // stddev_q8
);
  import swms_pkg::*;

  localparam int OUT_W    = ((FILL_W + MEAN_W + STD_W + 7) / 8) * 8;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SLOT_W   = $clog2(DEPTH);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(DEPTH);
  localparam int SQ_W     = 2 * SAMPLE_BITS - 1 + $clog2(DEPTH);
  localparam int MUL_W    = max2(max2(SUM_W, SAMPLE_BITS), CNT_W);
  localparam int VAR_W    = CNT_W + SQ_W;
  localparam int ROOT_W   = (VAR_W + 2 * FRAC_BITS + 1) / 2;
  localparam int DIV_W    = max2(SUM_W + FRAC_BITS, ROOT_W);
  localparam int RES_W    = max2(ROOT_W, DIV_W);
  localparam int SRC_W    = 2 * ROOT_W;
  localparam int WL_RESET = (WIN_RESET > DEPTH) ? DEPTH : WIN_RESET;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQN,
    ST_SQO,
    ST_NL,
    ST_NH,
    ST_ACC,
    ST_DIVM,
    ST_SQRT,
    ST_DIVS,
    ST_OUT
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         wl_q, wl_d;
  logic [CNT_W-1:0]         held_q, held_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [SQ_W-1:0]          sumsq_q, sumsq_d;
  logic                     evict_q, evict_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic [VAR_W-1:0]         acc_q, acc_d;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic [STD_W-1:0]         std_q, std_d;
  logic                     m_valid_q, m_valid_d;
  logic [OUT_W-1:0]         m_data_q, m_data_d;

  logic [SAMPLE_BITS-1:0]   ring_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic [2*MUL_W-1:0]       prod_q;

  logic                     in_beat;
  logic signed [SAMPLE_BITS-1:0] s_sample;
  logic [SAMPLE_BITS-1:0]   abs_x, abs_old;
  logic [SUM_W-1:0]         abs_sum;
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [CNT_W-1:0]         slot_inc;
  logic [CFG_W-1:0]         cfg_v;
  logic [RES_W:0]           q_round;
  logic signed [RES_W:0]    mean_full;

  swms_ctrl_t               u_ctrl;
  swms_stat_t               u_stat;
  logic [SRC_W-1:0]         u_op_a;
  logic [RES_W-1:0]         u_res;
  logic                     u_rem_nz;

  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_wr_en_i;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_sample      = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Magnitudes for the shared multiplier and the mean division
  assign abs_x    = x_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_q) : SAMPLE_BITS'(x_q);
  assign abs_old  = old_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-old_q) : SAMPLE_BITS'(old_q);
  assign abs_sum  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);
  assign cfg_v    = (cfg_wr_data_i == '0) ? CFG_W'(1) : cfg_wr_data_i;

  // Ring: write the new sample and read the evicted one at the same slot
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      old_q            <= $signed(ring_mem[slot_q]);
      ring_mem[slot_q] <= s_sample;
    end
  end

  // Shared multiplier operands
  always_comb begin
    unique case (state_q)
      ST_SUM:  begin mul_a = MUL_W'(abs_x);   mul_b = MUL_W'(abs_x);   end
      ST_SQN:  begin mul_a = MUL_W'(abs_old); mul_b = MUL_W'(abs_old); end
      ST_SQO:  begin mul_a = MUL_W'(abs_sum); mul_b = MUL_W'(abs_sum); end
      ST_NL:   begin mul_a = MUL_W'(held_q);  mul_b = sumsq_q[MUL_W-1:0]; end
      ST_NH:   begin mul_a = MUL_W'(held_q);  mul_b = MUL_W'(sumsq_q[SQ_W-1:MUL_W]); end
      default: begin mul_a = '0;              mul_b = '0;              end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Floored signed mean from quotient and remainder of |sum|*256 / n
  always_comb begin
    q_round   = (RES_W+1)'(u_res) + (RES_W+1)'(u_rem_nz);
    mean_full = sum_q[SUM_W-1] ? -$signed(q_round) : $signed((RES_W+1)'(u_res));
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    wl_d      = wl_q;
    held_d    = held_q;
    slot_d    = slot_q;
    sum_d     = sum_q;
    sumsq_d   = sumsq_q;
    evict_d   = evict_q;
    x_d       = x_q;
    acc_d     = acc_q;
    mean_d    = mean_q;
    std_d     = std_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    u_ctrl    = '{start: 1'b0, op: OP_DIV};
    u_op_a    = '0;

    // drop the output beat once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_wr_en_i) begin
          wl_d    = (32'(cfg_v) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cfg_v);
          held_d  = '0;
          slot_d  = '0;
          sum_d   = '0;
          sumsq_d = '0;
        end else if (in_beat) begin
          x_d     = s_sample;
          evict_d = (held_q >= wl_q);
          held_d  = (held_q >= wl_q) ? wl_q : held_q + CNT_W'(1);
          slot_d  = (slot_inc >= wl_q) ? '0 : SLOT_W'(slot_inc);
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d = sum_q + SUM_W'(x_q) - (evict_q ? SUM_W'(old_q) : SUM_W'(0));
        state_d = ST_SQN;
      end
      ST_SQN: begin
        sumsq_d = sumsq_q + SQ_W'(prod_q);
        state_d = ST_SQO;
      end
      ST_SQO: begin
        if (evict_q) begin
          sumsq_d = sumsq_q - SQ_W'(prod_q);
        end
        state_d = ST_NL;
      end
      ST_NL: begin
        // start from -sum^2; the final value is exact and non-negative
        acc_d   = VAR_W'(0) - VAR_W'(prod_q);
        state_d = ST_NH;
      end
      ST_NH: begin
        acc_d   = acc_q + VAR_W'(prod_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d     = acc_q + (VAR_W'(prod_q) << MUL_W);
        u_ctrl    = '{start: 1'b1, op: OP_DIV};
        u_op_a    = SRC_W'(abs_sum) << FRAC_BITS;
        state_d   = ST_DIVM;
      end
      ST_DIVM: begin
        if (u_stat.done) begin
          mean_d  = MEAN_W'(mean_full);
          u_ctrl  = '{start: 1'b1, op: OP_SQRT};
          u_op_a  = SRC_W'(acc_q) << (2 * FRAC_BITS);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (u_stat.done) begin
          u_ctrl  = '{start: 1'b1, op: OP_DIV};
          u_op_a  = SRC_W'(u_res);
          state_d = ST_DIVS;
        end
      end
      ST_DIVS: begin
        if (u_stat.done) begin
          std_d   = STD_W'(u_res);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({std_q, mean_q, FILL_W'(held_q)});
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wl_q      <= CNT_W'(WL_RESET);
      held_q    <= '0;
      slot_q    <= '0;
      sum_q     <= '0;
      sumsq_q   <= '0;
      evict_q   <= 1'b0;
      x_q       <= '0;
      acc_q     <= '0;
      mean_q    <= '0;
      std_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      wl_q      <= wl_d;
      held_q    <= held_d;
      slot_q    <= slot_d;
      sum_q     <= sum_d;
      sumsq_q   <= sumsq_d;
      evict_q   <= evict_d;
      x_q       <= x_d;
      acc_q     <= acc_d;
      mean_q    <= mean_d;
      std_q     <= std_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
    end
  end

  swms_sqdiv #(
    .ROOT_W (ROOT_W),
    .DIV_W  (DIV_W),
    .CNT_W  (CNT_W)
  ) u_sqdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (u_ctrl),
    .op_a_i    (u_op_a),
    .divisor_i (held_q),
    .stat_o    (u_stat),
    .result_o  (u_res),
    .rem_nz_o  (u_rem_nz)
  );

  // Checks
  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !u_stat.busy)
    else $error("shared unit busy while idle");

  a_held_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q <= wl_q) && (wl_q != '0))
    else $error("fill count beyond window length");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(slot_q) < wl_q)
    else $error("write slot outside window");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !cfg_wr_en_i) |=> (state_q == ST_SUM))
    else $error("accepted beat did not start processing");

endmodule
